/* sv/msp_pkg.sv */
package msp_pkg;

	// default build values for the top level parameters
	localparam int WORD_BYTES_DEF = 8;
	localparam int MAX_FRAC_DEF   = 9;

	// depth of the job queue between the parser and the scaler
	localparam int QUEUE_DEPTH = 2;

	// result status codes
	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_LETTER,
		ERR_SYMBOL,
		ERR_OVERFLOW
	} err_t;

	// one finished text, handed from parser to scaler
	typedef struct packed {
		logic [63:0] mantissa;
		logic [3:0]  frac_digits;
		logic [5:0]  prefix_shift;
		logic        unit_is_word;
		err_t        err;
	} job_t;

endpackage

/* sv/memory_size_string_parser.sv */
// Size text parser: turns a text such as "1.5 GB" into a byte count.
// Input channel: one ASCII character per transaction on character, with
// last_char high on the final one; a transaction happens when push is high
// and full is low. Characters are taken one per cycle while full is low;
// full rises only while the job queue (two finished texts) is full.
// Result channel: one transaction per text. size_value and status are valid
// while empty is low and are taken when pop is high.
// From the last character to the result, a text passes through the job fetch
// from the queue, denominator setup, 128 steps of the bit-serial divider
// and the write to the result register. Texts with a parse error skip the
// divider. One text is scaled at a time: the scaler fetches no new job
// until the result of the last one is written to the result register.
// Status: 0 ok, 1 bad unit letter, 2 unexpected symbol, 3 overflow
// (size_value all ones); on status 1 or 2 size_value is zero.
// Reset clears the parse state, the queue and the result register.
// While the receiver stalls the result holds; the scaler finishes the next
// text and waits, and the parser keeps taking characters until the queue fills.
module memory_size_string_parser #(
	parameter int WORD_BYTES          = msp_pkg::WORD_BYTES_DEF,
	parameter int MAX_FRACTION_DIGITS = msp_pkg::MAX_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  character,
	input  logic        last_char,
	input  logic        push,
	output logic        full,
	output logic [63:0] size_value,
	output logic [1:0]  status,
	output logic        empty,
	input  logic        pop
);

	logic           accept;
	logic           q_push, q_full, q_empty, q_take;
	msp_pkg::job_t  q_wdata, q_rdata;

	assign full   = q_full;
	assign accept = push && !q_full;

	msp_front #(
		.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.character (character),
		.last_char (last_char),
		.job_push  (q_push),
		.job       (q_wdata)
	);

	msp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_take),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	msp_back #(
		.WORD_BYTES(WORD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!q_empty),
		.job        (q_rdata),
		.job_take   (q_take),
		.pop        (pop),
		.empty      (empty),
		.size_value (size_value),
		.status     (status)
	);

	// a finished text is never pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("job pushed into full queue");

	// parse errors give a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == msp_pkg::ERR_LETTER || status == msp_pkg::ERR_SYMBOL))
		|-> (size_value == '0))
		else $error("error result with non-zero value");

	// overflow saturates
	a_ovf_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == msp_pkg::ERR_OVERFLOW) |-> (size_value == '1))
		else $error("overflow result not saturated");

	// the scaler only fetches a job that is there
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> !q_empty)
		else $error("job fetched from empty queue");

endmodule

/* sv/msp_front.sv */
module msp_front #(
	parameter int MAX_FRACTION_DIGITS = msp_pkg::MAX_FRAC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    character,
	input  logic          last_char,
	output logic          job_push,
	output msp_pkg::job_t job
);

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_INT,
		PH_FRAC,
		PH_PREFIX,
		PH_UNIT,
		PH_END
	} phase_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_K     = 8'h6B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [3:0] FRAC_MAX = 4'(MAX_FRACTION_DIGITS);

	phase_t         phase_q;
	logic [63:0]    mant_q;
	logic [3:0]     frac_q;
	logic [5:0]     shift_q;
	logic           word_q;
	msp_pkg::err_t  err_q;

	phase_t         phase_n;
	logic [63:0]    mant_n;
	logic [3:0]     frac_n;
	logic [5:0]     shift_n;
	logic           word_n;
	msp_pkg::err_t  err_n;

	logic           is_space, is_digit, is_alpha;
	logic [7:0]     lower;
	logic [5:0]     pfx;
	logic           unit_hit, unit_word;
	logic [67:0]    m10;

	// character classes
	always_comb begin
		lower    = character | 8'h20;
		is_space = (character == 8'h20) || (character >= 8'h09 && character <= 8'h0D);
		is_digit = character inside {[8'h30:8'h39]};
		is_alpha = character inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		case (lower)
			CH_K:    pfx = 6'd10;
			CH_M:    pfx = 6'd20;
			CH_G:    pfx = 6'd30;
			CH_T:    pfx = 6'd40;
			default: pfx = 6'd0;
		endcase
		unit_hit  = is_alpha && (lower == CH_B || lower == CH_O || lower == CH_W);
		unit_word = (lower == CH_W);
	end

	// mantissa times ten plus digit, carry above bit 63 is overflow
	assign m10 = ({4'd0, mant_q} << 3) + ({4'd0, mant_q} << 1) + 68'(character[3:0]);

	// phase walk for one character
	always_comb begin
		phase_t ph;
		logic   skip, take_letter, take_unit, take_digit;
		ph          = phase_q;
		skip        = 1'b0;
		take_letter = 1'b0;
		take_unit   = 1'b0;
		take_digit  = 1'b0;
		phase_n     = phase_q;
		mant_n      = mant_q;
		frac_n      = frac_q;
		shift_n     = shift_q;
		word_n      = word_q;
		err_n       = err_q;
		if (err_q == msp_pkg::ERR_NONE) begin
			if (ph == PH_LEAD) begin
				if (is_space) skip = 1'b1;
				else ph = PH_INT;
			end
			if (!skip) begin
				phase_n = ph;
				case (ph)
					PH_INT, PH_FRAC: begin
						if (is_alpha) begin
							take_letter = 1'b1;
						end else if (ph == PH_INT &&
							(character == CH_COMMA || character == CH_POINT)) begin
							phase_n = PH_FRAC;
						end else if (is_digit) begin
							if (ph == PH_INT) begin
								take_digit = 1'b1;
							end else if (frac_q < FRAC_MAX) begin
								take_digit = 1'b1;
								frac_n     = frac_q + 4'd1;
							end
						end else if (is_space) begin
							phase_n = PH_PREFIX;
						end else begin
							err_n = msp_pkg::ERR_SYMBOL;
						end
					end
					PH_PREFIX: begin
						if (is_alpha) take_letter = 1'b1;
						else if (!is_space) err_n = msp_pkg::ERR_SYMBOL;
					end
					PH_UNIT: begin
						if (is_alpha) take_unit = 1'b1;
						else if (!is_space) err_n = msp_pkg::ERR_SYMBOL;
					end
					default: begin
						if (!is_space) err_n = msp_pkg::ERR_SYMBOL;
					end
				endcase
				// prefix letter, else try it as a unit
				if (take_letter) begin
					if (pfx != 6'd0) begin
						shift_n = pfx;
						phase_n = PH_UNIT;
					end else begin
						take_unit = 1'b1;
					end
				end
				if (take_unit) begin
					if (!unit_hit) begin
						err_n = msp_pkg::ERR_LETTER;
					end else begin
						word_n  = unit_word;
						phase_n = PH_END;
					end
				end
				if (take_digit) begin
					if (m10[67:64] != 4'd0) err_n = msp_pkg::ERR_OVERFLOW;
					else mant_n = m10[63:0];
				end
			end
		end
	end

	// hand the finished text to the queue
	assign job_push = accept && last_char;
	always_comb begin
		job.mantissa     = mant_n;
		job.frac_digits  = frac_n;
		job.prefix_shift = shift_n;
		job.unit_is_word = word_n;
		job.err          = err_n;
	end

	// parse state, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			mant_q  <= '0;
			frac_q  <= '0;
			shift_q <= '0;
			word_q  <= 1'b0;
			err_q   <= msp_pkg::ERR_NONE;
		end else if (accept) begin
			if (last_char) begin
				phase_q <= PH_LEAD;
				mant_q  <= '0;
				frac_q  <= '0;
				shift_q <= '0;
				word_q  <= 1'b0;
				err_q   <= msp_pkg::ERR_NONE;
			end else begin
				phase_q <= phase_n;
				mant_q  <= mant_n;
				frac_q  <= frac_n;
				shift_q <= shift_n;
				word_q  <= word_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

/* sv/msp_queue.sv */
module msp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  msp_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output msp_pkg::job_t rd_data,
	output logic          empty
);

	localparam int DEPTH = msp_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	msp_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
			if (do_rd) rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

endmodule

/* sv/msp_back.sv */
module msp_back #(
	parameter int WORD_BYTES = msp_pkg::WORD_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  msp_pkg::job_t job,
	output logic          job_take,
	input  logic          pop,
	output logic          empty,
	output logic [63:0]   size_value,
	output logic [1:0]    status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam logic [63:0] WB = 64'(WORD_BYTES);

	function automatic logic [63:0] pow10(input logic [3:0] k);
		logic [63:0] v;
		case (k)
			4'd0:    v = 64'd1;
			4'd1:    v = 64'd10;
			4'd2:    v = 64'd100;
			4'd3:    v = 64'd1000;
			4'd4:    v = 64'd10000;
			4'd5:    v = 64'd100000;
			4'd6:    v = 64'd1000000;
			4'd7:    v = 64'd10000000;
			4'd8:    v = 64'd100000000;
			4'd9:    v = 64'd1000000000;
			4'd10:   v = 64'd10000000000;
			4'd11:   v = 64'd100000000000;
			4'd12:   v = 64'd1000000000000;
			4'd13:   v = 64'd10000000000000;
			4'd14:   v = 64'd100000000000000;
			default: v = 64'd1000000000000000;
		endcase
		return v;
	endfunction

	state_t         state_q;
	msp_pkg::job_t  job_q;
	logic [63:0]    den_q;
	logic [127:0]   div_q;
	logic [63:0]    rem_q, quo_q;
	logic           ovf_q;
	logic [6:0]     cnt_q;
	logic           out_valid_q;
	logic [63:0]    value_q;
	logic [1:0]     status_q;

	logic [64:0]    rem_sh, rem_nx;
	logic           ge;
	logic           out_free;
	logic [63:0]    res_value;
	msp_pkg::err_t  res_status;

	assign job_take   = (state_q == ST_IDLE) && job_valid;
	assign out_free   = !out_valid_q || pop;
	assign empty      = !out_valid_q;
	assign size_value = value_q;
	assign status     = status_q;

	// one restoring division step
	always_comb begin
		rem_sh = {rem_q, div_q[127]};
		ge     = (rem_sh >= {1'b0, den_q});
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	// final value and status
	always_comb begin
		if (job_q.err != msp_pkg::ERR_NONE) begin
			res_status = job_q.err;
			res_value  = (job_q.err == msp_pkg::ERR_OVERFLOW) ? '1 : '0;
		end else if (ovf_q) begin
			res_status = msp_pkg::ERR_OVERFLOW;
			res_value  = '1;
		end else begin
			res_status = msp_pkg::ERR_NONE;
			res_value  = quo_q;
		end
	end

	// sequencer, divider registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			den_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			status_q    <= '0;
			cnt_q       <= '0;
		end else begin
			// result taken; in the done state the new result replaces it
			if (pop && out_valid_q && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					den_q <= job_q.unit_is_word ? pow10(job_q.frac_digits) * WB
						: pow10(job_q.frac_digits);
					div_q <= {64'd0, job_q.mantissa} << job_q.prefix_shift;
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					cnt_q <= '0;
					state_q <= (job_q.err != msp_pkg::ERR_NONE) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					div_q <= {div_q[126:0], 1'b0};
					rem_q <= rem_nx[63:0];
					quo_q <= {quo_q[62:0], ge};
					// a quotient bit in the upper half does not fit
					if (ge && !cnt_q[6]) ovf_q <= 1'b1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						value_q     <= res_value;
						status_q    <= res_status;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
